@@ sv/nps_pkg.sv @@
// ---------------------------------------------------------------------------
// nps_pkg: shared types and constants for the nine-point stencil step
// Grid geometry, fixed-point widths, pipeline tags and the window tap select.
// ---------------------------------------------------------------------------
package nps_pkg;

  localparam int LANES      = 8;
  localparam int GRID_COLS  = 256;
  localparam int GRID_ROWS  = 256;
  localparam int SAMPLE_W   = 16;

  localparam int ROW_VECS   = GRID_COLS / LANES;
  localparam int FRAME_VECS = ROW_VECS * GRID_ROWS;
  localparam int RUN_LEN    = FRAME_VECS + ROW_VECS + 1;

  localparam int POS_W      = $clog2(RUN_LEN);
  localparam int COL_W      = (ROW_VECS > 1) ? $clog2(ROW_VECS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int VEC_W      = LANES * SAMPLE_W;

  // 0.10 quantized to 18 fractional bits
  localparam int WEIGHT_W   = 17;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_Q18 = 17'sd26214;

  // 4*axis + diag, weight product, pre-round sum
  localparam int SUM_W      = SAMPLE_W + 5;
  localparam int PROD_W     = SUM_W + WEIGHT_W;
  localparam int PFLR_W     = PROD_W - 16;
  localparam int ACC_W      = PFLR_W + 1;
  localparam int QUO_W      = ACC_W - 4;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0] vec_t;
  typedef vec_t [2:0] wrow_t;
  typedef wrow_t [2:0] win_t;

  // one line-store entry: the two rows held for a vector column
  typedef struct packed {
    vec_t top;
    vec_t mid;
  } line_t;

  // control that travels alongside a vector through the pipeline
  typedef struct packed {
    logic             valid;
    logic             frame_end;
    logic [LANES-1:0] pass_lane;
  } tag_t;

  // neighbourhood tap: row 0..2, pos 0..LANES+1 across the halo
  function automatic sample_t nb(input win_t w, input int row, input int pos);
    sample_t v;
    if (pos <= 0) begin
      v = sample_t'(w[row][0][LANES-1]);
    end else if (pos > LANES) begin
      v = sample_t'(w[row][2][0]);
    end else begin
      v = sample_t'(w[row][1][pos-1]);
    end
    return v;
  endfunction

endpackage

@@ sv/nps_line_ram.sv @@
// ---------------------------------------------------------------------------
// nps_line_ram: two-row line store
// One entry per vector column holds the two previous rows; one write port,
// one read port, registered read data.
// ---------------------------------------------------------------------------
module nps_line_ram import nps_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  line_t            wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output line_t            rdata
);

  line_t mem [ROW_VECS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/nps_feed.sv @@
// ---------------------------------------------------------------------------
// nps_feed: position tracking, line store and 3x3 vector window
// Reads the line store on accept and writes the rotated rows back the next
// cycle, with forwarding for back-to-back hits, and shifts the window.
// ---------------------------------------------------------------------------
module nps_feed import nps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  vec_t in_vec,
  input  logic in_drain,
  output logic emit_issue,
  output win_t win,
  output tag_t win_tag
);

  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] ocol;
  logic [ROW_W-1:0] orow;

  logic  take;
  logic  emit;
  logic  row_edge;
  vec_t  fresh;
  tag_t  tag0;

  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  vec_t             s1_fresh;
  tag_t             s1_tag;
  logic             s1_fwd;
  line_t            s1_fwd_data;
  logic             s1_seen;

  logic [ROW_VECS-1:0] seen;
  line_t ram_q;
  line_t rd;
  line_t wr_data;

  always_comb begin
    take     = (pos < POS_W'(FRAME_VECS)) && !in_drain;
    fresh    = take ? in_vec : '0;
    emit     = (pos >= POS_W'(ROW_VECS + 1));
    row_edge = (orow == '0) || (orow == ROW_W'(GRID_ROWS - 1));
    tag0.valid     = emit;
    tag0.frame_end = (orow == ROW_W'(GRID_ROWS - 1)) && (ocol == COL_W'(ROW_VECS - 1));
    tag0.pass_lane = {LANES{row_edge}};
    tag0.pass_lane[0]       = row_edge || (ocol == '0);
    tag0.pass_lane[LANES-1] = tag0.pass_lane[LANES-1] || (ocol == COL_W'(ROW_VECS - 1));
    emit_issue = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      col  <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (accept) begin
      if (pos == POS_W'(RUN_LEN - 1)) begin
        pos <= '0;
        col <= '0;
      end else begin
        pos <= pos + 1'b1;
        col <= (col == COL_W'(ROW_VECS - 1)) ? '0 : col + 1'b1;
      end
      if (emit) begin
        if (ocol == COL_W'(ROW_VECS - 1)) begin
          ocol <= '0;
          orow <= (orow == ROW_W'(GRID_ROWS - 1)) ? '0 : orow + 1'b1;
        end else begin
          ocol <= ocol + 1'b1;
        end
      end
    end
  end

  nps_line_ram u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col),
    .rdata (ram_q)
  );

  // unwritten entries read as zero; same-column write in flight is forwarded
  always_comb begin
    if (s1_fwd) begin
      rd = s1_fwd_data;
    end else if (s1_seen) begin
      rd = ram_q;
    end else begin
      rd = '0;
    end
    wr_data.top = rd.mid;
    wr_data.mid = s1_fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      seen     <= '0;
    end else begin
      s1_valid <= accept;
      if (s1_valid) begin
        seen[s1_col] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= col;
      s1_fresh    <= fresh;
      s1_tag      <= tag0;
      s1_fwd      <= s1_valid && (s1_col == col);
      s1_fwd_data <= wr_data;
      s1_seen     <= seen[col];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd.top;
      win[1][2] <= rd.mid;
      win[2][2] <= s1_fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_tag.valid <= 1'b0;
    end else begin
      win_tag.valid     <= s1_valid && s1_tag.valid;
      win_tag.frame_end <= s1_tag.frame_end;
      win_tag.pass_lane <= s1_tag.pass_lane;
    end
  end

endmodule

@@ sv/nps_kernel.sv @@
// ---------------------------------------------------------------------------
// nps_kernel: per-lane stencil arithmetic
// Neighbour sums, weight multiply, convergent rounding and saturation, with the
// sums and the product registered; edge lanes pass the center through.
// ---------------------------------------------------------------------------
module nps_kernel import nps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  win_t win,
  input  tag_t win_tag,
  output logic push,
  output logic push_last,
  output vec_t push_vec
);

  tag_t t2;
  tag_t t3;

  logic signed [SUM_W-1:0]  c2   [LANES];
  sample_t                  ctr2 [LANES];
  logic signed [PROD_W-1:0] p3   [LANES];
  sample_t                  ctr3 [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [SUM_W-1:0]  axis;
    logic signed [SUM_W-1:0]  diag;
    logic signed [PFLR_W-1:0] pflr;
    logic signed [ACC_W-1:0]  s;
    logic signed [QUO_W-1:0]  q;
    logic signed [QUO_W:0]    qr;
    logic [3:0]               rem;
    logic                     up;
    sample_t                  sat;

    always_comb begin
      axis = SUM_W'(nb(win, 0, k + 1)) + SUM_W'(nb(win, 2, k + 1))
           + SUM_W'(nb(win, 1, k))     + SUM_W'(nb(win, 1, k + 2));
      diag = SUM_W'(nb(win, 0, k))     + SUM_W'(nb(win, 0, k + 2))
           + SUM_W'(nb(win, 2, k))     + SUM_W'(nb(win, 2, k + 2));
    end

    always_ff @(posedge clk) begin
      c2[k]   <= (axis <<< 2) + diag;
      ctr2[k] <= nb(win, 1, k + 1);
      p3[k]   <= PROD_W'(c2[k]) * PROD_W'(WEIGHT_Q18);
      ctr3[k] <= ctr2[k];
    end

    // floor of product to 2^-17, then round half-even by 16
    always_comb begin
      pflr = p3[k][PROD_W-1:16];
      s    = (ACC_W'(ctr3[k]) <<< 3) + ACC_W'(pflr);
      q    = s[ACC_W-1:4];
      rem  = s[3:0];
      up   = (rem > 4'd8) || ((rem == 4'd8) && q[0]);
      qr   = (QUO_W+1)'(q) + (QUO_W+1)'(up);
      if (qr > (QUO_W+1)'(32767)) begin
        sat = 16'sh7fff;
      end else if (qr < -(QUO_W+1)'(32768)) begin
        sat = 16'sh8000;
      end else begin
        sat = qr[SAMPLE_W-1:0];
      end
      push_vec[k] = t3.pass_lane[k] ? ctr3[k] : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
    end else begin
      t2 <= win_tag;
      t3 <= t2;
    end
  end

  assign push      = t3.valid;
  assign push_last = t3.frame_end;

endmodule

@@ sv/nps_out_fifo.sv @@
// ---------------------------------------------------------------------------
// nps_out_fifo: result queue
// Decouples the free-running pipeline from the downstream receiver.
// ---------------------------------------------------------------------------
module nps_out_fifo import nps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_last,
  input  vec_t push_vec,
  input  logic pop,
  output logic valid,
  output logic out_last,
  output vec_t out_vec
);

  logic [VEC_W:0]     mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {push_last, push_vec};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign valid    = (count != '0);
  assign out_last = mem[rd_ptr][VEC_W];
  assign out_vec  = mem[rd_ptr][VEC_W-1:0];

endmodule

@@ sv/nine_point_stencil_step.sv @@
// ---------------------------------------------------------------------------
// nine_point_stencil_step: 3x3 smoothing over a row-major vector stream
// Smooths a grid of Q3.13 samples eight lanes at a time.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one row-major grid vector per transaction; tuser set marks
//   a drain transaction (samples read as zero). A frame is GRID_ROWS rows of
//   ROW_VECS vectors followed by ROW_VECS+1 drain transactions.
//   m_axis carries one smoothed vector per transaction from the (ROW_VECS+2)th
//   input of a frame on; tlast marks the last vector of the grid.
//   Each output belongs to the input one row plus one vector earlier; it is
//   registered in s1, the window, t2, t3 and the queue before m_axis.
//   Throughput is one vector per cycle while s_axis_tready is high: the line
//   store is read on accept and written back the next cycle, with forwarding
//   when the column repeats. Results queue in an 8-entry FIFO; s_axis_tready
//   drops only while 8 results are owed (queued or in the pipeline), so a
//   stalled receiver stops input after at most 8 results and loses nothing.
//   Reset empties the pipeline and queue and marks every line-store entry as
//   zero; no clearing pass is needed, the block is ready the cycle after.
// ---------------------------------------------------------------------------
module nine_point_stencil_step import nps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [VEC_W-1:0] s_axis_tdata,   // sample_0 .. sample_7, 16 bits each
  input  logic             s_axis_tuser,   // drain
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VEC_W-1:0] m_axis_tdata,   // result_0 .. result_7, 16 bits each
  output logic             m_axis_tlast
);

  logic             accept;
  logic             pop;
  logic             emit_issue;
  logic [FIFO_AW:0] owed;
  win_t             win;
  tag_t             win_tag;
  logic             push;
  logic             push_last;
  vec_t             push_vec;
  vec_t             out_vec;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (owed < (FIFO_AW+1)'(FIFO_DEPTH));
  assign m_axis_tdata  = out_vec;

  // results promised: in the pipeline or waiting in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + (FIFO_AW+1)'(emit_issue) - (FIFO_AW+1)'(pop);
    end
  end

  nps_feed u_feed (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_vec     (s_axis_tdata),
    .in_drain   (s_axis_tuser),
    .emit_issue (emit_issue),
    .win        (win),
    .win_tag    (win_tag)
  );

  nps_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .win_tag   (win_tag),
    .push      (push),
    .push_last (push_last),
    .push_vec  (push_vec)
  );

  nps_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_last (push_last),
    .push_vec  (push_vec),
    .pop       (pop),
    .valid     (m_axis_tvalid),
    .out_last  (m_axis_tlast),
    .out_vec   (out_vec)
  );

endmodule

@@ sv/nps_checker.sv @@
// ---------------------------------------------------------------------------
// nps_checker: port-level checks for the stencil step
// Watches the stream ports for hold, latency and flow-control slips.
// ---------------------------------------------------------------------------
module nps_checker import nps_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [VEC_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // input only backs up when enough results are queued to show one
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with nothing to deliver");

  // an empty queue fills only from an earlier accepted input transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 5))
    else $error("result without matching input");

endmodule

bind nine_point_stencil_step nps_checker u_nps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ dv/nine_point_stencil_step_tb.sv @@
// ---------------------------------------------------------------------------
// nine_point_stencil_step_tb: self-checking bench for the 3x3 stencil step
// Streams the upper rows of a grid frame, well into the smoothed interior.
// Results are checked lane by lane against an in-bench model of the smoother.
// Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module nine_point_stencil_step_tb import nps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int N_DIR       = 16;
  localparam int N_ITEMS     = 1150;  // input transactions in the whole run
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE      = 16;

  typedef enum int {FILL_ANY, FILL_HIGH, FILL_LOW, FILL_TINY, FILL_RAIL} fill_t;
  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_t;

  typedef struct packed {
    vec_t lanes;
    logic last;
  } smoothed_t;

  typedef struct packed {
    vec_t d;
    logic drn;
    vec_t pin;    // result expected for this cell once it comes out
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [VEC_W-1:0] s_axis_tdata;   // sample_0 .. sample_7, 16 bits each
  logic             s_axis_tuser;   // drain
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [VEC_W-1:0] m_axis_tdata;   // result_0 .. result_7, 16 bits each
  logic             m_axis_tlast;

  nine_point_stencil_step dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // smoother model state
  sample_t     rows_held[2][ROW_VECS][LANES];
  sample_t     nbhd[3][3][LANES];
  int          run_pos;
  int          frame_count;
  smoothed_t   smoothed_q[$];
  dir_row_t    dir_rows[N_DIR];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // window tap, pos 0 and LANES+1 are the halo lanes of the side vectors
  function automatic longint tap(input int r, input int pos);
    if (pos <= 0) begin
      return nbhd[r][0][LANES-1];
    end else if (pos > LANES) begin
      return nbhd[r][2][0];
    end
    return nbhd[r][1][pos-1];
  endfunction

  function automatic sample_t blend(input int k);
    longint ctr, axis, diag, c, p, s, q, rem;
    ctr  = tap(1, k+1);
    axis = tap(0, k+1) + tap(2, k+1) + tap(1, k) + tap(1, k+2);
    diag = tap(0, k) + tap(0, k+2) + tap(2, k) + tap(2, k+2);
    c    = 4 * axis + diag;                         // 2^-15 units
    p    = (c * longint'(WEIGHT_Q18)) >>> 16;       // truncated, 2^-17 units
    s    = 8 * ctr + p;
    q    = s >>> 4;
    rem  = s - q * 16;
    // half to even
    if (rem > 8 || (rem == 8 && q[0])) begin
      q++;
    end
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return sample_t'(q);
  endfunction

  task automatic smooth_step(input vec_t d, input logic drn);
    int        col, cur, grow, gvec, gcol;
    logic      take;
    sample_t   fresh[LANES];
    sample_t   top[LANES];
    sample_t   mid[LANES];
    smoothed_t res;
    col  = run_pos % ROW_VECS;
    take = (run_pos < FRAME_VECS) && !drn;
    for (int k = 0; k < LANES; k++) begin
      fresh[k] = take ? sample_t'(d[k]) : sample_t'(0);
      top[k]   = rows_held[0][col][k];
      mid[k]   = rows_held[1][col][k];
      rows_held[0][col][k] = mid[k];
      rows_held[1][col][k] = fresh[k];
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < LANES; k++) begin
        nbhd[r][0][k] = nbhd[r][1][k];
        nbhd[r][1][k] = nbhd[r][2][k];
      end
    end
    for (int k = 0; k < LANES; k++) begin
      nbhd[0][2][k] = top[k];
      nbhd[1][2][k] = mid[k];
      nbhd[2][2][k] = fresh[k];
    end
    cur = run_pos - (ROW_VECS + 1);
    if (cur >= 0 && cur < FRAME_VECS) begin
      grow = cur / ROW_VECS;
      gvec = cur % ROW_VECS;
      for (int k = 0; k < LANES; k++) begin
        gcol = gvec * LANES + k;
        if (grow == 0 || grow == GRID_ROWS-1 || gcol == 0 || gcol == GRID_COLS-1) begin
          res.lanes[k] = sample_t'(tap(1, k+1));
        end else begin
          res.lanes[k] = blend(k);
        end
      end
      res.last = (cur == FRAME_VECS-1);
      if (frame_count == 0 && cur < N_DIR) begin
        res.lanes = dir_rows[cur].pin;
      end
      smoothed_q.push_back(res);
    end
    run_pos++;
    if (run_pos >= RUN_LEN) begin
      run_pos = 0;
      frame_count++;
    end
  endtask

  initial begin
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < ROW_VECS; j++)
        for (int k = 0; k < LANES; k++)
          rows_held[i][j][k] = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < LANES; k++)
          nbhd[i][j][k] = '0;
    run_pos      = 0;
    frame_count  = 0;
    mismatches   = 0;
    results_seen = 0;
  end

  // output check first, then the model takes the accepted input
  always @(posedge clk) begin
    smoothed_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.lanes = m_axis_tdata;
      got.last  = m_axis_tlast;
      if (smoothed_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d with none pending", results_seen));
      end else begin
        exp_r = smoothed_q.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (got.lanes[k] !== exp_r.lanes[k]) begin
            flag_mismatch($sformatf("result %0d lane %0d: got %h, expected %h",
                                    results_seen, k, got.lanes[k], exp_r.lanes[k]));
          end
        end
        if (got.last !== exp_r.last) begin
          flag_mismatch($sformatf("result %0d tlast: got %b, expected %b",
                                  results_seen, got.last, exp_r.last));
        end
      end
      results_seen++;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      smooth_step(s_axis_tdata, s_axis_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned pick_gap(input idle_t mode);
    int unsigned r;
    if (mode == IDLE_NONE) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < ((mode == IDLE_LIGHT) ? 70 : 30)) begin
      return 0;
    end else if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic fill_t pick_fill();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return FILL_ANY;
    if (r < 55) return FILL_HIGH;
    if (r < 70) return FILL_LOW;
    if (r < 90) return FILL_TINY;
    return FILL_RAIL;
  endfunction

  function automatic sample_t make_sample(input fill_t f);
    case (f)
      FILL_HIGH: begin
        if ($urandom_range(0, 3) == 0) return 16'sh7fff;
        return sample_t'($urandom_range(24576, 32767));
      end
      FILL_LOW: begin
        return sample_t'(0 - int'($urandom_range(24576, 32768)));
      end
      FILL_TINY: begin
        return sample_t'(int'($urandom_range(0, 48)) - 24);
      end
      FILL_RAIL: begin
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  task automatic send_vec(input vec_t d, input logic drn, input idle_t mode);
    int unsigned gap;
    gap = pick_gap(mode);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= drn;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic put_row(input int i, input vec_t d, input logic drn, input vec_t pin);
    dir_rows[i].d   = d;
    dir_rows[i].drn = drn;
    dir_rows[i].pin = pin;
  endtask

  // receiver: random stalls, sometimes none for a long stretch
  initial begin
    idle_t       mode;
    int unsigned stall;
    m_axis_tready = 1'b0;
    mode          = IDLE_NONE;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        mode = idle_t'($urandom_range(0, 2));
      end
      stall = pick_gap(mode);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    int unsigned sent;
    int          gen_pos;
    fill_t       band[ROW_VECS];
    idle_t       send_idle;
    vec_t        d;
    logic        drn;

    // grid row 0 is all edge cells: each comes back as its own center
    put_row(0,  '0,                                   1'b0, '0);
    put_row(1,  {LANES{16'h7fff}},                    1'b0, {LANES{16'h7fff}});
    put_row(2,  {LANES{16'h8000}},                    1'b0, {LANES{16'h8000}});
    put_row(3,  {4{16'h8000, 16'h7fff}},              1'b0, {4{16'h8000, 16'h7fff}});
    put_row(4,  {4{16'h7fff, 16'h8000}},              1'b0, {4{16'h7fff, 16'h8000}});
    put_row(5,  {LANES{16'h0001}},                    1'b0, {LANES{16'h0001}});
    put_row(6,  {LANES{16'hffff}},                    1'b0, {LANES{16'hffff}});
    put_row(7,  {LANES{16'h5555}},                    1'b0, {LANES{16'h5555}});
    put_row(8,  {LANES{16'haaaa}},                    1'b0, {LANES{16'haaaa}});
    // drain inside the frame reads as zero samples
    put_row(9,  {LANES{16'h7fff}},                    1'b1, '0);
    put_row(10, {16'h8000, 16'h6000, 16'h4000, 16'h2000,
                 16'he000, 16'hc000, 16'ha000, 16'h0001}, 1'b0,
                {16'h8000, 16'h6000, 16'h4000, 16'h2000,
                 16'he000, 16'hc000, 16'ha000, 16'h0001});
    put_row(11, {LANES{16'h2000}},                    1'b0, {LANES{16'h2000}});
    put_row(12, {LANES{16'he000}},                    1'b0, {LANES{16'he000}});
    put_row(13, {LANES{16'h1234}},                    1'b1, '0);
    put_row(14, {LANES{16'h0008}},                    1'b0, {LANES{16'h0008}});
    put_row(15, {LANES{16'h7ffe}},                    1'b0, {LANES{16'h7ffe}});

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sent      = 0;
    gen_pos   = 0;
    send_idle = IDLE_NONE;
    for (int i = 0; i < N_DIR; i++) begin
      send_vec(dir_rows[i].d, dir_rows[i].drn, send_idle);
      sent++;
      gen_pos++;
    end

    for (int j = 0; j < ROW_VECS; j++) band[j] = pick_fill();
    // random rows down the upper part of the frame
    while (sent < N_ITEMS) begin
      // fill style held per column for bands of four rows, so whole
      // neighbourhoods sit at the rails
      if (gen_pos % (4 * ROW_VECS) == 0) begin
        for (int j = 0; j < ROW_VECS; j++) band[j] = pick_fill();
      end
      if (sent % 150 == 0) begin
        send_idle = idle_t'($urandom_range(0, 2));
      end
      if (gen_pos < FRAME_VECS) begin
        drn = ($urandom_range(0, 49) == 0);
      end else begin
        // some data items while the frame waits for drain
        drn = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < LANES; k++) begin
        d[k] = make_sample(band[gen_pos % ROW_VECS]);
      end
      send_vec(d, drn, send_idle);
      sent++;
      gen_pos = (gen_pos + 1) % RUN_LEN;
    end
    s_axis_tvalid <= 1'b0;

    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
